@@ hw/rtl/tberc_pkg.sv @@
package tberc_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Fixed field widths of the configuration and the result word
    localparam int THRESH_WIDTH = 16;
    localparam int OUT_WIDTH    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int RATE_WIDTH   = FRAC_BITS + 1;

    // APB side
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;

    // Register indexes
    localparam logic REG_ZERO_THRESHOLD = 1'b0;

endpackage

@@ hw/rtl/tberc_sym_if.sv @@
interface tberc_sym_if #(
    parameter int SAMPLE_WIDTH = tberc_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] est_real;
    logic signed [SAMPLE_WIDTH-1:0] est_imag;
    logic signed [SAMPLE_WIDTH-1:0] true_real;
    logic signed [SAMPLE_WIDTH-1:0] true_imag;
    logic                           is_pilot;
    logic                           last_item;

    modport source (
        output valid, est_real, est_imag, true_real, true_imag, is_pilot, last_item,
        input  ready
    );

    modport sink (
        input  valid, est_real, est_imag, true_real, true_imag, is_pilot, last_item,
        output ready
    );
endinterface

@@ hw/rtl/tberc_res_if.sv @@
interface tberc_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [tberc_pkg::OUT_WIDTH-1:0]      error_bits;
    logic [tberc_pkg::OUT_WIDTH-1:0]      counted_bits;
    logic [tberc_pkg::RATE_WIDTH-1:0]     error_rate;
    logic                                 no_bits;

    modport source (
        output valid, error_bits, counted_bits, error_rate, no_bits,
        input  ready
    );

    modport sink (
        input  valid, error_bits, counted_bits, error_rate, no_bits,
        output ready
    );
endinterface

@@ hw/rtl/ternary_bit_error_rate_counter.sv @@
// Bit error rate counter for QPSK symbols with an extra zero symbol.
//
// sym (sink): one word per symbol - estimate, truth, pilot flag and a
//   last flag. Data words are counted in the cycle they are accepted, so
//   a stream of non-last words runs at one word per cycle.
// res (source): one word per measured block, given after the word marked
//   last: error count, bit count, Q1.16 error rate and an empty flag.
// cfg (APB): zero_threshold at byte address 0, written in the access
//   phase; pready is tied high. Write only while the block is idle.
//
// Divide after a last word: one shared subtractor runs a restoring divide,
// one compare step plus one step per fraction bit, then ST_HOLD moves the
// result into the result register. The early cases (no bits counted, error
// rate of one) end after the compare step. sym.ready is low from the last
// word until the result has gone into the output register.
// The result register holds its word until res.ready; while it is full a
// new block may be counted, and the next block result waits in the
// sequencer. Reset clears the counters, the threshold and res.valid.
module ternary_bit_error_rate_counter #(
    parameter int SAMPLE_WIDTH = tberc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = tberc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    tberc_sym_if.sink                              sym,
    tberc_res_if.source                            res,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tberc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [tberc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [tberc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                   pready
);

    localparam int TW     = tberc_pkg::THRESH_WIDTH;
    localparam int OW     = tberc_pkg::OUT_WIDTH;
    localparam int RW     = tberc_pkg::RATE_WIDTH;
    localparam int FB     = tberc_pkg::FRAC_BITS;
    localparam int DW     = tberc_pkg::APB_DATA_WIDTH;
    // L1 norm of two samples needs one bit more than a sample magnitude
    localparam int L1W    = (SAMPLE_WIDTH + 1 > TW) ? SAMPLE_WIDTH + 1 : TW;
    localparam int EXTW   = (COUNT_WIDTH > OW) ? COUNT_WIDTH : OW;
    localparam int STEP_W = $clog2(FB + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [TW-1:0]           thresh_reg;
    logic [COUNT_WIDTH-1:0]  err_acc_reg, err_acc_next;
    logic [COUNT_WIDTH-1:0]  bit_acc_reg, bit_acc_next;
    logic [COUNT_WIDTH-1:0]  snap_err_reg, snap_err_next;
    logic [COUNT_WIDTH-1:0]  snap_bits_reg, snap_bits_next;
    logic [COUNT_WIDTH-1:0]  rem_reg, rem_next;
    // quotient bits before the final one; the final bit goes straight out
    logic [FB-2:0]           quo_reg, quo_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [RW-1:0]           rate_res_reg, rate_res_next;
    logic                    none_res_reg, none_res_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OW-1:0]           out_err_reg, out_err_next;
    logic [OW-1:0]           out_bits_reg, out_bits_next;
    logic [RW-1:0]           out_rate_reg, out_rate_next;
    logic                    out_none_reg, out_none_next;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[tberc_pkg::APB_ADDR_WIDTH-1] == tberc_pkg::REG_ZERO_THRESHOLD);
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[tberc_pkg::APB_ADDR_WIDTH-1])
            tberc_pkg::REG_ZERO_THRESHOLD: prdata = DW'(thresh_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= '0;
        else if (cfg_wr)
            thresh_reg <= pwdata[TW-1:0];
    end

    // ---------------- symbol decision ----------------
    logic [SAMPLE_WIDTH-1:0] mag_re, mag_im;
    logic [L1W-1:0]          l1;
    logic                    est_zero, true_zero;
    logic                    re_neg_e, re_pos_e, re_neg_t, re_pos_t;
    logic                    im_neg_e, im_pos_e, im_neg_t, im_pos_t;
    logic                    re_err, im_err;
    logic [1:0]              sym_errs;

    assign mag_re = sym.est_real[SAMPLE_WIDTH-1] ? (~sym.est_real + 1'b1) : sym.est_real;
    assign mag_im = sym.est_imag[SAMPLE_WIDTH-1] ? (~sym.est_imag + 1'b1) : sym.est_imag;
    assign l1        = L1W'(mag_re) + L1W'(mag_im);
    assign est_zero  = l1 < L1W'(thresh_reg);
    assign true_zero = (sym.true_real == '0);

    assign re_neg_e = sym.est_real[SAMPLE_WIDTH-1];
    assign re_pos_e = !re_neg_e && (sym.est_real != '0);
    assign re_neg_t = sym.true_real[SAMPLE_WIDTH-1];
    assign re_pos_t = !re_neg_t && (sym.true_real != '0);
    assign im_neg_e = sym.est_imag[SAMPLE_WIDTH-1];
    assign im_pos_e = !im_neg_e && (sym.est_imag != '0);
    assign im_neg_t = sym.true_imag[SAMPLE_WIDTH-1];
    assign im_pos_t = !im_neg_t && (sym.true_imag != '0);
    assign re_err   = (re_neg_e && re_pos_t) || (re_pos_e && re_neg_t);
    assign im_err   = (im_neg_e && im_pos_t) || (im_pos_e && im_neg_t);

    always_comb
    begin
        if (est_zero != true_zero)
            sym_errs = 2'd2;
        else if (!est_zero)
            sym_errs = {1'b0, re_err} + {1'b0, im_err};
        else
            sym_errs = 2'd0;
    end

    // saturating counter updates
    logic [COUNT_WIDTH:0]   err_sum, bit_sum;
    logic [COUNT_WIDTH-1:0] err_upd, bit_upd;

    assign err_sum = {1'b0, err_acc_reg} + (COUNT_WIDTH + 1)'(sym_errs);
    assign bit_sum = {1'b0, bit_acc_reg} + (COUNT_WIDTH + 1)'(2);
    assign err_upd = sym.is_pilot ? err_acc_reg
                   : (err_sum[COUNT_WIDTH] ? '1 : err_sum[COUNT_WIDTH-1:0]);
    assign bit_upd = sym.is_pilot ? bit_acc_reg
                   : (bit_sum[COUNT_WIDTH] ? '1 : bit_sum[COUNT_WIDTH-1:0]);

    // ---------------- shared divide step ----------------
    // step 0 compares errors against bits (rate of one), later steps
    // shift the remainder in one fraction bit at a time
    logic                   sym_acc;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH+1:0] diff;
    logic                   ge;
    logic                   first_step;
    logic                   last_step;

    assign sym_acc    = sym.valid && sym.ready;
    assign sym.ready  = (state_reg == ST_IDLE);
    assign first_step = (step_reg == '0);
    assign last_step  = (step_reg == STEP_W'(FB));
    assign trial      = first_step ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign diff       = {1'b0, trial} - {2'b00, snap_bits_reg};
    assign ge         = !diff[COUNT_WIDTH+1];

    logic [EXTW-1:0] err_ext, bits_ext;
    assign err_ext  = EXTW'(snap_err_reg);
    assign bits_ext = EXTW'(snap_bits_reg);

    always_comb
    begin
        state_next     = state_reg;
        err_acc_next   = err_acc_reg;
        bit_acc_next   = bit_acc_reg;
        snap_err_next  = snap_err_reg;
        snap_bits_next = snap_bits_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        rate_res_next  = rate_res_reg;
        none_res_next  = none_res_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_err_next   = out_err_reg;
        out_bits_next  = out_bits_reg;
        out_rate_next  = out_rate_reg;
        out_none_next  = out_none_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sym_acc)
                begin
                    if (sym.last_item)
                    begin
                        snap_err_next  = err_upd;
                        snap_bits_next = bit_upd;
                        rem_next       = err_upd;
                        quo_next       = '0;
                        step_next      = '0;
                        err_acc_next   = '0;
                        bit_acc_next   = '0;
                        state_next     = ST_DIV;
                    end
                    else
                    begin
                        err_acc_next = err_upd;
                        bit_acc_next = bit_upd;
                    end
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (first_step)
                begin
                    if (snap_bits_reg == '0)
                    begin
                        rate_res_next = '0;
                        none_res_next = 1'b1;
                        state_next    = ST_HOLD;
                    end
                    else if (ge)
                    begin
                        rate_res_next = RW'(1) << FB;
                        none_res_next = 1'b0;
                        state_next    = ST_HOLD;
                    end
                end
                else
                begin
                    rem_next = ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
                    quo_next = {quo_reg[FB-3:0], ge};
                    if (last_step)
                    begin
                        rate_res_next = {1'b0, quo_reg, ge};
                        none_res_next = 1'b0;
                        state_next    = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = err_ext[OW-1:0];
                    out_bits_next  = bits_ext[OW-1:0];
                    out_rate_next  = rate_res_reg;
                    out_none_next  = none_res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            err_acc_reg   <= '0;
            bit_acc_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_acc_reg   <= err_acc_next;
            bit_acc_reg   <= bit_acc_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_err_reg  <= snap_err_next;
        snap_bits_reg <= snap_bits_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        rate_res_reg  <= rate_res_next;
        none_res_reg  <= none_res_next;
        out_err_reg   <= out_err_next;
        out_bits_reg  <= out_bits_next;
        out_rate_reg  <= out_rate_next;
        out_none_reg  <= out_none_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.error_bits   = out_err_reg;
    assign res.counted_bits = out_bits_reg;
    assign res.error_rate   = out_rate_reg;
    assign res.no_bits      = out_none_reg;

`ifndef SYNTHESIS
    // at most two errors per two counted bits, saturation included
    a_err_le_bits: assert property (@(posedge clk) disable iff (!rst_n)
        err_acc_reg <= bit_acc_reg)
        else $error("error count above bit count");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (sym.valid && sym.ready && sym.last_item) |=>
            (err_acc_reg == '0) && (bit_acc_reg == '0) && !sym.ready)
        else $error("counters not cleared or still ready after last word");

    a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result word without a finished divide");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!res.error_rate[RW-1] || (res.error_rate[FB-1:0] == '0))
                      && (!res.no_bits || (res.error_rate == '0)))
        else $error("error rate out of range");
`endif

endmodule
